[design/sine_tone_generator_unit_assert.svh]
// assertion macros for the sine tone generator
// expects clk and rst_n in the scope of the module that uses them
`ifndef SINE_TONE_GENERATOR_UNIT_ASSERT_SVH
`define SINE_TONE_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define STG_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define STG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/stg_pkg.sv]
// shared types, constants and the sine table for the sine tone generator
// no dependencies
`default_nettype none

package stg_pkg;

    localparam int TABLE_SIZE       = 45;
    localparam int CLOCK_HZ         = 25000000;
    localparam int REFERENCE_OCTAVE = 4;

    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int CNT32_W    = 32;
    localparam int NOTE_W     = 12;
    localparam int OCT_W      = 4;
    localparam int BEATS_W    = 4;
    localparam int BPM_W      = 10;
    localparam int DAC_W      = 10;
    localparam int VOL_W      = 4;
    localparam int FREQ_W     = NOTE_W + REFERENCE_OCTAVE;
    localparam int DIVIDEND_W = $clog2(CLOCK_HZ + 1);
    localparam int DIVISOR_W  = FREQ_W + $clog2(TABLE_SIZE + 1);
    localparam int STEP_W     = $clog2(DIVIDEND_W + 1);
    localparam int DURNUM_W   = 10;
    localparam int PROD_W     = 2 * DIVIDEND_W;

    localparam logic [VOL_W-1:0] VOL_MAX     = 4'd10;
    localparam logic [VOL_W-1:0] VOL_DEFAULT = 4'd5;
    localparam int               MIDPOINT    = 410;
    localparam int               SECS_PER_MIN = 60;

    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_PLAY = 2'd1;
    localparam logic [1:0] ACT_STOP = 2'd2;

    localparam logic [DAC_W-1:0] SINE_ROM [TABLE_SIZE] = '{
        10'd410, 10'd467, 10'd523, 10'd576, 10'd627, 10'd673, 10'd714, 10'd749, 10'd778,
        10'd799, 10'd813, 10'd819, 10'd817, 10'd807, 10'd789, 10'd764, 10'd732, 10'd694,
        10'd650, 10'd602, 10'd550, 10'd495, 10'd438, 10'd381, 10'd324, 10'd270, 10'd217,
        10'd169, 10'd125, 10'd87,  10'd55,  10'd30,  10'd12,  10'd2,   10'd0,   10'd6,
        10'd20,  10'd41,  10'd70,  10'd105, 10'd146, 10'd193, 10'd243, 10'd297, 10'd353
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PERIOD,
        ST_DURATION,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [NOTE_W-1:0]  note_hz;
        logic [OCT_W-1:0]   octave;
        logic [BEATS_W-1:0] beats;
        logic [BPM_W-1:0]   tempo_bpm;
    } req_t;

    typedef struct packed {
        logic [DAC_W-1:0] dac_value;
        logic             playing;
        logic             sample_strobe;
    } rsp_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

    // table entry scaled around the midpoint by the divisor 10 / volume,
    // truncating toward zero; volume zero is handled by the caller
    function automatic logic [DAC_W-1:0] scale_sample(
        input logic [IDX_W-1:0] idx,
        input logic [VOL_W-1:0] vol
    );
        logic signed [DAC_W:0] centered;
        logic [8:0]            mag;
        logic [18:0]           prod;
        logic [8:0]            q;
        logic signed [DAC_W:0] v;
        centered = signed'({1'b0, SINE_ROM[idx]}) - 11'(MIDPOINT);
        mag      = centered[DAC_W] ? 9'(-centered) : 9'(centered);
        prod     = '0;
        case (vol) inside
            4'd1:
            begin
                // divide by ten
                prod = 19'(mag) * 19'd205;
                q    = 9'(prod >> 11);
            end
            4'd2:
            begin
                // divide by five
                prod = 19'(mag) * 19'd205;
                q    = 9'(prod >> 10);
            end
            4'd3:
            begin
                // divide by three
                prod = 19'(mag) * 19'd683;
                q    = 9'(prod >> 11);
            end
            [4'd4:4'd5]: q = mag >> 1;
            default:     q = mag;
        endcase
        v = centered[DAC_W] ? -signed'({2'b00, q}) : signed'({2'b00, q});
        v = v + 11'(MIDPOINT);
        return DAC_W'(v);
    endfunction

endpackage

`default_nettype wire

[design/sine_tone_generator_unit.sv]
// tick and stop items: result registered the cycle after accept, one item per
// cycle while rsp_stall is low; play items wait on the shared restoring divider
// (one quotient bit per cycle), used once for the sample period and once for
// the beat count; no new item is taken meanwhile
// reset (rst_n low, asynchronous): not playing, counters zero, volume 5
`default_nettype none
`include "sine_tone_generator_unit_assert.svh"

module sine_tone_generator_unit (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // request channel
    input  wire logic                      req_valid,
    output logic                           req_stall,
    input  wire stg_pkg::req_t             req,
    // result channel
    output logic                           rsp_valid,
    input  wire logic                      rsp_stall,
    output stg_pkg::rsp_t                  rsp,
    // volume register
    input  wire logic                      cfg_write_en,
    input  wire logic [stg_pkg::VOL_W-1:0] cfg_write_data
);

    localparam logic [stg_pkg::CNT32_W-1:0] CNT_MAX = '1;

    // sequencer and tone state
    stg_pkg::state_t                  state_reg, state_next;
    logic [stg_pkg::VOL_W-1:0]        volume_reg;
    logic [stg_pkg::IDX_W-1:0]        idx_reg, idx_next;
    logic [stg_pkg::CNT32_W-1:0]      scnt_reg, scnt_next;
    logic [stg_pkg::CNT32_W-1:0]      period_reg, period_next;
    logic [stg_pkg::CNT32_W-1:0]      dcnt_reg, dcnt_next;
    logic [stg_pkg::CNT32_W-1:0]      limit_reg, limit_next;
    logic                             active_reg, active_next;
    logic [stg_pkg::DAC_W-1:0]        outv_reg, outv_next;

    // operands held for the second divide
    logic [stg_pkg::DURNUM_W-1:0]     durnum_reg, durnum_next;
    logic [stg_pkg::BPM_W-1:0]        bpm_reg, bpm_next;

    // output register
    logic                             rsp_valid_reg, rsp_valid_next;
    stg_pkg::rsp_t                    rsp_reg, rsp_next;

    // shared divider
    stg_pkg::div_req_t                div_req;
    stg_pkg::div_rsp_t                div_rsp;

    logic                             slot_free;
    logic                             accept;
    logic                             emit;
    logic                             strobe;
    logic [stg_pkg::FREQ_W-1:0]       freq;
    logic [stg_pkg::CNT32_W-1:0]      scnt_inc;
    logic [stg_pkg::CNT32_W-1:0]      dcnt_inc;
    logic [stg_pkg::PROD_W-1:0]       dur_prod;

    stg_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // output slot is free when empty or being taken this cycle
    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != stg_pkg::ST_IDLE) || !slot_free;
    assign accept    = req_valid && !req_stall;

    // note shifted by octave relative to the reference octave
    always_comb
    begin
        if (req.octave <= stg_pkg::OCT_W'(stg_pkg::REFERENCE_OCTAVE))
            freq = stg_pkg::FREQ_W'(req.note_hz)
                   << (stg_pkg::OCT_W'(stg_pkg::REFERENCE_OCTAVE) - req.octave);
        else
            freq = stg_pkg::FREQ_W'(req.note_hz
                   >> (req.octave - stg_pkg::OCT_W'(stg_pkg::REFERENCE_OCTAVE)));
    end

    // saturating counter increments for a tick
    assign scnt_inc = (scnt_reg == CNT_MAX) ? scnt_reg : scnt_reg + 1'b1;
    assign dcnt_inc = (dcnt_reg == CNT_MAX) ? dcnt_reg : dcnt_reg + 1'b1;

    // clock rate times whole beat-seconds, from the registered quotient
    assign dur_prod = stg_pkg::PROD_W'(div_rsp.quotient)
                      * stg_pkg::PROD_W'(stg_pkg::CLOCK_HZ);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        scnt_next      = scnt_reg;
        period_next    = period_reg;
        dcnt_next      = dcnt_reg;
        limit_next     = limit_reg;
        active_next    = active_reg;
        outv_next      = outv_reg;
        durnum_next    = durnum_reg;
        bpm_next       = bpm_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        div_req        = '0;
        emit           = 1'b0;
        strobe         = 1'b0;

        case (state_reg)
            stg_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    emit = 1'b1;
                    case (req.action)
                        stg_pkg::ACT_PLAY:
                        begin
                            if (freq == '0)
                            begin
                                // zero frequency behaves as a stop
                                idx_next    = '0;
                                scnt_next   = '0;
                                dcnt_next   = '0;
                                active_next = 1'b0;
                                outv_next   = '0;
                            end
                            else
                            begin
                                // period = clock / (freq * table size)
                                emit             = 1'b0;
                                div_req.start    = 1'b1;
                                div_req.dividend = stg_pkg::DIVIDEND_W'(stg_pkg::CLOCK_HZ);
                                div_req.divisor  = stg_pkg::DIVISOR_W'(freq)
                                    * stg_pkg::DIVISOR_W'(stg_pkg::TABLE_SIZE);
                                durnum_next      = stg_pkg::DURNUM_W'(req.beats)
                                    * stg_pkg::DURNUM_W'(stg_pkg::SECS_PER_MIN);
                                bpm_next         = req.tempo_bpm;
                                state_next       = stg_pkg::ST_PERIOD;
                            end
                        end
                        stg_pkg::ACT_STOP:
                        begin
                            idx_next    = '0;
                            scnt_next   = '0;
                            dcnt_next   = '0;
                            active_next = 1'b0;
                            outv_next   = '0;
                        end
                        stg_pkg::ACT_TICK:
                        begin
                            if (active_reg)
                            begin
                                // sample handling first
                                scnt_next = scnt_inc;
                                if (scnt_inc >= period_reg)
                                begin
                                    scnt_next = '0;
                                    strobe    = 1'b1;
                                    if (volume_reg == '0)
                                        outv_next = '0;
                                    else
                                    begin
                                        outv_next = stg_pkg::scale_sample(idx_reg, volume_reg);
                                        if (idx_reg ==
                                            stg_pkg::IDX_W'(stg_pkg::TABLE_SIZE - 1))
                                            idx_next = '0;
                                        else
                                            idx_next = idx_reg + 1'b1;
                                    end
                                end
                                // then the duration check
                                dcnt_next = dcnt_inc;
                                if (dcnt_inc >= limit_reg)
                                begin
                                    idx_next    = '0;
                                    scnt_next   = '0;
                                    dcnt_next   = '0;
                                    active_next = 1'b0;
                                    outv_next   = '0;
                                end
                            end
                        end
                        default:
                        begin
                            // unused action code: no change
                        end
                    endcase
                end
            end
            stg_pkg::ST_PERIOD:
            begin
                if (div_rsp.done)
                begin
                    period_next = (div_rsp.quotient == '0) ? stg_pkg::CNT32_W'(1)
                                  : stg_pkg::CNT32_W'(div_rsp.quotient);
                    // seconds = (60 * beats) / bpm, bpm zero taken as one
                    div_req.start    = 1'b1;
                    div_req.dividend = stg_pkg::DIVIDEND_W'(durnum_reg);
                    div_req.divisor  = (bpm_reg == '0) ? stg_pkg::DIVISOR_W'(1)
                                       : stg_pkg::DIVISOR_W'(bpm_reg);
                    state_next       = stg_pkg::ST_DURATION;
                end
            end
            stg_pkg::ST_DURATION:
            begin
                if (div_rsp.done)
                begin
                    limit_next  = (|dur_prod[stg_pkg::PROD_W-1:stg_pkg::CNT32_W]) ? CNT_MAX
                                  : dur_prod[stg_pkg::CNT32_W-1:0];
                    scnt_next   = '0;
                    dcnt_next   = '0;
                    active_next = 1'b1;
                    state_next  = stg_pkg::ST_FINISH;
                end
            end
            stg_pkg::ST_FINISH:
            begin
                // deliver the play item's result once the slot opens
                if (slot_free)
                begin
                    emit       = 1'b1;
                    state_next = stg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stg_pkg::ST_IDLE;
            end
        endcase

        if (emit)
        begin
            rsp_valid_next         = 1'b1;
            rsp_next.dac_value     = outv_next;
            rsp_next.playing       = active_next;
            rsp_next.sample_strobe = strobe;
        end
    end

    // control and tone state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stg_pkg::ST_IDLE;
            idx_reg       <= '0;
            scnt_reg      <= '0;
            period_reg    <= '0;
            dcnt_reg      <= '0;
            limit_reg     <= '0;
            active_reg    <= 1'b0;
            outv_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            scnt_reg      <= scnt_next;
            period_reg    <= period_next;
            dcnt_reg      <= dcnt_next;
            limit_reg     <= limit_next;
            active_reg    <= active_next;
            outv_reg      <= outv_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // volume register, out-of-range writes fall back to the default
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            volume_reg <= stg_pkg::VOL_DEFAULT;
        else if (cfg_write_en)
            volume_reg <= (cfg_write_data <= stg_pkg::VOL_MAX) ? cfg_write_data
                          : stg_pkg::VOL_DEFAULT;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        durnum_reg <= durnum_next;
        bpm_reg    <= bpm_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `STG_ASSERT_IMPL(a_busy_stalls, state_reg != stg_pkg::ST_IDLE, req_stall,
        "request taken while a play item is in progress")
    `STG_ASSERT_IMPL(a_period_set, active_reg, period_reg != '0,
        "tone active with zero sample period")
    `STG_ASSERT_IMPL(a_index_range, 1'b1,
        idx_reg <= stg_pkg::IDX_W'(stg_pkg::TABLE_SIZE - 1),
        "table index beyond the sine table")
    `STG_ASSERT_NEXT(a_period_to_dur, state_reg == stg_pkg::ST_PERIOD && div_rsp.done,
        state_reg == stg_pkg::ST_DURATION,
        "period divide finished without starting the duration divide")

endmodule

`default_nettype wire

[design/stg_divider.sv]
// restoring divider, one quotient bit per cycle
// depends on stg_pkg for widths and the request and response structs
`default_nettype none

module stg_divider (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire stg_pkg::div_req_t req,
    output stg_pkg::div_rsp_t     rsp
);

    localparam logic [stg_pkg::STEP_W-1:0] LAST_STEP =
        stg_pkg::STEP_W'(stg_pkg::DIVIDEND_W - 1);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [stg_pkg::STEP_W-1:0]       step_reg, step_next;
    logic [stg_pkg::DIVISOR_W-1:0]    rem_reg, rem_next;
    logic [stg_pkg::DIVIDEND_W-1:0]   quo_reg, quo_next;
    logic [stg_pkg::DIVISOR_W-1:0]    dvsr_reg, dvsr_next;

    logic [stg_pkg::DIVISOR_W:0]      shifted;
    logic [stg_pkg::DIVISOR_W:0]      diff;
    logic                             fits;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[stg_pkg::DIVIDEND_W-1]};
        diff      = shifted - {1'b0, dvsr_reg};
        fits      = shifted >= {1'b0, dvsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvsr_next = dvsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvsr_next = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[stg_pkg::DIVISOR_W-1:0] : shifted[stg_pkg::DIVISOR_W-1:0];
            quo_next  = {quo_reg[stg_pkg::DIVIDEND_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvsr_reg <= dvsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire
